FILE: src/keyboard_fifo_mmio_core_defines.svh
// ----------------------------------------------------------------------------
// keyboard_fifo_mmio_core_defines.svh
// Assertion macros shared by the keyboard FIFO modules.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_FIFO_MMIO_CORE_DEFINES_SVH
`define KEYBOARD_FIFO_MMIO_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/kfm_pkg.sv
// ----------------------------------------------------------------------------
// kfm_pkg
// Types and constants shared by the keyboard FIFO controller and datapath.
// ----------------------------------------------------------------------------
package kfm_pkg;

    localparam int FIFO_DEPTH_DEF = 256;
    localparam int LIMIT_W        = 9;
    localparam int READ_W         = 9;
    localparam int KEY_W          = 8;
    localparam int ADDR_W         = 8;
    localparam int WDATA_W        = 32;
    localparam int OP_W           = 2;
    localparam int S_TDATA_W      = KEY_W + ADDR_W + WDATA_W;
    localparam int M_TDATA_W      = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd16;
    localparam logic [ADDR_W-1:0]  ADDR_DATA   = 8'h00;
    localparam logic [ADDR_W-1:0]  ADDR_STATUS = 8'h04;

    localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } kfm_state_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_COUNT,
        OUT_MEM
    } kfm_out_sel_t;

    typedef struct packed {
        logic         push;
        logic         pop;
        logic         clear;
        logic         out_load;
        kfm_out_sel_t out_sel;
    } kfm_cmd_t;

    typedef struct packed {
        logic is_key;
        logic is_rd_data;
        logic is_rd_status;
        logic is_rd_other;
        logic is_clear;
        logic can_push;
        logic empty;
    } kfm_status_t;

endpackage

FILE: src/kfm_datapath.sv
// ----------------------------------------------------------------------------
// kfm_datapath
// Key byte store, head/tail/count pointers, limit register and result register.
// ----------------------------------------------------------------------------
module kfm_datapath
    import kfm_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [OP_W-1:0]      op,
    input  logic [KEY_W-1:0]     key_code,
    input  logic [ADDR_W-1:0]    address,
    input  logic [WDATA_W-1:0]   write_data,
    input  logic                 cfg_wr_en,
    input  logic [LIMIT_W-1:0]   cfg_wr_data,
    input  kfm_cmd_t             cmd,
    output kfm_status_t          status,
    output logic [READ_W-1:0]    read_data
);

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [KEY_W-1:0]   mem [FIFO_DEPTH];
    logic [KEY_W-1:0]   mem_rdata_reg;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [READ_W-1:0]  read_data_reg;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        next_slot = (idx == IDX_W'(FIFO_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Decode the item for the controller.
    always_comb begin
        status.is_key       = (op == OP_KEY);
        status.is_rd_data   = (op == OP_READ) && (address == ADDR_DATA);
        status.is_rd_status = (op == OP_READ) && (address == ADDR_STATUS);
        status.is_rd_other  = (op == OP_READ) && (address != ADDR_DATA)
                              && (address != ADDR_STATUS);
        status.is_clear     = (op == OP_WRITE) && (address == ADDR_STATUS)
                              && (write_data != '0);
        status.can_push     = (LIMIT_W'(count_reg) < limit_reg)
                              && (count_reg < CNT_W'(FIFO_DEPTH));
        status.empty        = (count_reg == '0);
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end else if (cmd.push) begin
            tail_next  = next_slot(tail_reg);
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // Store: one write port at the tail, one registered read port at the head.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= key_code;
        end
        if (cmd.pop) begin
            mem_rdata_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OUT_COUNT: read_data_reg <= READ_W'(count_reg);
                OUT_MEM:   read_data_reg <= READ_W'(mem_rdata_reg);
                default:   read_data_reg <= '0;
            endcase
        end
    end

    assign read_data = read_data_reg;

`include "keyboard_fifo_mmio_core_defines.svh"

    `KFM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(FIFO_DEPTH), "count above depth")
    `KFM_ASSERT_NOW(a_pop_nonempty, cmd.pop, !status.empty, "pop from empty store")
    `KFM_ASSERT_NEXT(a_clear_empties, cmd.clear, count_reg == '0, "clear left bytes")

endmodule

FILE: src/kfm_ctrl.sv
// ----------------------------------------------------------------------------
// kfm_ctrl
// Sequencer: accepts items, issues datapath commands, owns the result valid.
// ----------------------------------------------------------------------------
module kfm_ctrl
    import kfm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  kfm_status_t status,
    output kfm_cmd_t    cmd
);

    kfm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        accept       = 1'b0;
        cmd.push     = 1'b0;
        cmd.pop      = 1'b0;
        cmd.clear    = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_sel  = OUT_ZERO;
        case (state_reg)
            ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                accept   = s_tvalid && s_tready;
                if (accept) begin
                    if (status.is_key) begin
                        cmd.push = status.can_push;
                    end else if (status.is_rd_data) begin
                        if (status.empty) begin
                            cmd.out_load = 1'b1;
                        end else begin
                            cmd.pop    = 1'b1;
                            state_next = ST_POP;
                        end
                    end else if (status.is_rd_status) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_COUNT;
                    end else if (status.is_rd_other) begin
                        cmd.out_load = 1'b1;
                    end else if (status.is_clear) begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            ST_POP: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_MEM;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

`include "keyboard_fifo_mmio_core_defines.svh"

    `KFM_ASSERT_NEXT(a_pop_shows, state_reg == ST_POP, m_tvalid, "popped byte not shown")
    `KFM_ASSERT_NOW(a_pop_blocks, state_reg == ST_POP, !s_tready, "input taken during pop")
    `KFM_ASSERT_NOW(a_no_overwrite, s_tready && out_valid_reg, m_tready, "result overwritten")

endmodule

FILE: src/keyboard_fifo_mmio_core.sv
// ----------------------------------------------------------------------------
// keyboard_fifo_mmio_core
// Keyboard peripheral: byte FIFO of key codes behind a data and status register.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one item per transfer: s_tuser is the kind
//   (key press, bus read, bus write), s_tdata holds key code, bus offset and
//   write value. A key press stores its byte while the count is below the
//   limit (cfg_wr_en/cfg_wr_data) and the depth, else drops it. A bus read
//   returns exactly one transfer on m_tdata: offset 0 pops the oldest byte
//   (0 when empty), offset 4 gives the count, other offsets give 0. A
//   non-zero write to offset 4 empties the FIFO; key presses and writes
//   return nothing. Timing: key presses, writes and reads other than a pop
//   let a following item enter the next cycle; a read result shows in the
//   cycle after its transfer. A pop goes through the registered read port
//   of the byte store and then the result register, blocking input meanwhile.
//   Reset (aresetn low, synchronous) empties the FIFO, restores a limit of 16
//   and drops any pending result; the store contents are not cleared.
//   While m_tready is low with a result pending, s_tready stays low; the
//   result holds on m_tdata until taken.
// ----------------------------------------------------------------------------
module keyboard_fifo_mmio_core
    import kfm_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: key_code [7:0], address [15:8], write_data [47:16]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // s_tuser: op [1:0]
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata: read_data [8:0], zero fill [15:9]
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_wr_en,
    input  logic [LIMIT_W-1:0]     cfg_wr_data
);

    kfm_cmd_t          cmd;
    kfm_status_t       status;
    logic [READ_W-1:0] read_data;

    // Sequence the transfers and own the result valid.
    kfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the bytes, pointers, limit and result register.
    kfm_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (s_tuser),
        .key_code    (s_tdata[KEY_W-1:0]),
        .address     (s_tdata[KEY_W+ADDR_W-1:KEY_W]),
        .write_data  (s_tdata[S_TDATA_W-1:KEY_W+ADDR_W]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .read_data   (read_data)
    );

    assign m_tdata = M_TDATA_W'(read_data);

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyboard FIFO peripheral: key presses and bus
// accesses stream in, every read result is compared with a local model of
// the FIFO, and the byte limit is swept through its extremes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import kfm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Unused kind code: the block must swallow it without a result.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT  = 3000;
    // Cycles a pop needs to settle; used before a limit write.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    typedef enum logic { ROW_ACCESS, ROW_LIMIT } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key_code;
        logic [ADDR_W-1:0] address;
        logic [WDATA_W-1:0] write_data;
        bit                typed;      // row carries a hand-written read result
        logic [READ_W-1:0] typed_val;  // or the new limit for a ROW_LIMIT row
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [OP_W-1:0]       s_tuser     = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wr_data = '0;

    // Hand-written expectation that travels with the item on the bus.
    logic                  row_typed     = 1'b0;
    logic [READ_W-1:0]     row_typed_val = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    keyboard_fifo_mmio_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // FIFO model: byte store, pointers, count and limit
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0]   key_mem [FIFO_DEPTH_DEF];
    logic [7:0]         head_ptr   = '0;
    logic [7:0]         tail_ptr   = '0;
    logic [LIMIT_W-1:0] held_bytes = '0;
    logic [LIMIT_W-1:0] byte_limit = LIMIT_RESET;

    // Read results still owed by the block, oldest first.
    logic [READ_W-1:0]  owed_reads [$];

    int fail_count    = 0;
    int keys_stored   = 0;
    int keys_dropped  = 0;
    int bytes_popped  = 0;
    int fifo_clears   = 0;
    int reads_checked = 0;
    int limit_writes  = 0;
    int quiet_cycles  = 0;

    // Apply one transfer to the model; return 1 when it yields a read result.
    function automatic bit predict_access(
        input  logic [OP_W-1:0]    op,
        input  logic [KEY_W-1:0]   key_code,
        input  logic [ADDR_W-1:0]  address,
        input  logic [WDATA_W-1:0] write_data,
        output logic [READ_W-1:0]  read_data
    );
        read_data = '0;
        case (op)
            OP_KEY: begin
                if (held_bytes < byte_limit && held_bytes < FIFO_DEPTH_DEF) begin
                    key_mem[tail_ptr] = key_code;
                    tail_ptr   = tail_ptr + 8'd1;
                    held_bytes = held_bytes + 1'b1;
                    keys_stored++;
                end else begin
                    keys_dropped++;
                end
                return 1'b0;
            end
            OP_READ: begin
                if (address == ADDR_DATA) begin
                    if (held_bytes != 0) begin
                        read_data  = {1'b0, key_mem[head_ptr]};
                        head_ptr   = head_ptr + 8'd1;
                        held_bytes = held_bytes - 1'b1;
                        bytes_popped++;
                    end
                end else if (address == ADDR_STATUS) begin
                    read_data = held_bytes;
                end
                return 1'b1;
            end
            OP_WRITE: begin
                if (address == ADDR_STATUS && write_data != 0) begin
                    head_ptr   = '0;
                    tail_ptr   = '0;
                    held_bytes = '0;
                    fifo_clears++;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check result transfers first, then track limit writes and
    // input transfers of the same edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [READ_W-1:0] predicted;
        logic [READ_W-1:0] owed;
        bit                gives_read;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (owed_reads.size() == 0) begin
                    $error("read_data: no result owed, got %0d", m_tdata[READ_W-1:0]);
                    fail_count++;
                end else begin
                    owed = owed_reads.pop_front();
                    reads_checked++;
                    if (m_tdata[READ_W-1:0] !== owed) begin
                        $error("read_data mismatch: expected %0d, got %0d",
                               owed, m_tdata[READ_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[M_TDATA_W-1:READ_W] !== '0) begin
                        $error("zero fill mismatch: expected 0, got %0h",
                               m_tdata[M_TDATA_W-1:READ_W]);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                byte_limit = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                gives_read = predict_access(s_tuser, s_tdata[7:0], s_tdata[15:8],
                                            s_tdata[47:16], predicted);
                if (gives_read) begin
                    owed_reads.insert(owed_reads.size(),
                                      row_typed ? row_typed_val : predicted);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up once nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Draw an idle count of 0..9, with occasional runs of back-to-back items.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall at random, and twice hold off for a long stretch so
    // the pending result backs up into the input
    // ------------------------------------------------------------------------
    initial begin
        int rx_burst;
        int rx_gap;
        int results_taken;
        rx_burst      = 0;
        results_taken = 0;
        @(posedge aclk iff aresetn);
        forever begin
            rx_gap = draw_gap(rx_burst);
            if (results_taken == 15 || results_taken == 100) begin
                rx_gap = 80;
            end
            if (rx_gap != 0) begin
                m_tready <= 1'b0;
                repeat (rx_gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            results_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    int tx_burst = 0;

    // Offer one item after a random idle stretch; return once it is taken.
    task automatic send_access(
        input logic [OP_W-1:0]    op,
        input logic [KEY_W-1:0]   key_code,
        input logic [ADDR_W-1:0]  address,
        input logic [WDATA_W-1:0] write_data,
        input bit                 typed,
        input logic [READ_W-1:0]  typed_val
    );
        int tx_gap;
        tx_gap = draw_gap(tx_burst);
        if (tx_gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (tx_gap) @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tuser       <= op;
        s_tdata       <= {write_data, address, key_code};
        row_typed     <= typed;
        row_typed_val <= typed_val;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Change the limit only with the block idle: hold the input, drain all
    // owed results, let a late pop settle, then write for one cycle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_reads.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_writes++;
    endtask

    // One random item; key and write shares are given per mille.
    task automatic send_random(input int key_pm, input int write_pm);
        int                 roll;
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  address;
        logic [WDATA_W-1:0] write_data;
        roll       = $urandom_range(0, 999);
        write_data = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
        address    = ADDR_W'($urandom_range(0, 255));
        if (roll < key_pm) begin
            op = OP_KEY;
        end else if (roll < key_pm + write_pm) begin
            op = OP_WRITE;
            if ($urandom_range(0, 9) < 4) address = ADDR_STATUS;
        end else if (roll < key_pm + write_pm + 10) begin
            op = OP_UNUSED;
        end else begin
            op = OP_READ;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8: address = ADDR_DATA;
                9, 10, 11, 12, 13, 14, 15: address = ADDR_STATUS;
                default: ;
            endcase
        end
        send_access(op, KEY_W'($urandom_range(0, 255)), address, write_data, 1'b0, '0);
    endtask

    stim_row_t directed_rows [$];

    task automatic add_row(
        input row_kind_t          kind,
        input logic [OP_W-1:0]    op,
        input logic [KEY_W-1:0]   key_code,
        input logic [ADDR_W-1:0]  address,
        input logic [WDATA_W-1:0] write_data,
        input bit                 typed,
        input logic [READ_W-1:0]  typed_val
    );
        stim_row_t row;
        row.kind       = kind;
        row.op         = op;
        row.key_code   = key_code;
        row.address    = address;
        row.write_data = write_data;
        row.typed      = typed;
        row.typed_val  = typed_val;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Random phases: limit, item count, key share, write share (per mille).
    // Start wide open so the store fills to its depth, hold the limit at the
    // depth, tighten it under the held count, mix, then shut the FIFO entirely.
    localparam int PHASES = 5;
    int phase_limit [PHASES] = '{511, 256, 2, -1, 0};
    int phase_items [PHASES] = '{300, 40, 80, 80, 30};
    int phase_keys  [PHASES] = '{950, 500, 250, 450, 500};
    int phase_wr    [PHASES] = '{3, 0, 20, 60, 50};

    initial begin
        stim_row_t row;
        // Hold reset low at the start, then release it at an edge.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; the limit is at its reset value of 16 here.
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_STATUS, 32'h0, 1'b1, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_DATA,   32'h0, 1'b1, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, 8'hFF,       32'h0, 1'b1, 9'd0);
        add_row(ROW_ACCESS, OP_KEY,    8'h00, 8'h00,       32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_KEY,    8'hFF, 8'hFF,       32'hFFFFFFFF, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_KEY,    8'h81, ADDR_STATUS, 32'h1, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'hFF, ADDR_STATUS, 32'hFFFFFFFF, 1'b0, 9'd0);
        // unused kind with every field at all ones: nothing may change
        add_row(ROW_ACCESS, OP_UNUSED, 8'hFF, 8'hFF,       32'hFFFFFFFF, 1'b0, 9'd0);
        // writes that must not clear: zero to status, anything elsewhere
        add_row(ROW_ACCESS, OP_WRITE,  8'h00, ADDR_STATUS, 32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_WRITE,  8'h00, ADDR_DATA,   32'hFFFFFFFF, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_WRITE,  8'h00, 8'hFF,       32'hFFFFFFFF, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_DATA,   32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_STATUS, 32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, 8'h01,       32'h0, 1'b1, 9'd0);
        // top bit alone is a non-zero clear
        add_row(ROW_ACCESS, OP_WRITE,  8'h00, ADDR_STATUS, 32'h80000000, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_STATUS, 32'h0, 1'b1, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_DATA,   32'h0, 1'b1, 9'd0);
        // limit of one: second key is dropped
        add_row(ROW_LIMIT,  OP_KEY,    8'h00, 8'h00,       32'h0, 1'b0, 9'd1);
        add_row(ROW_ACCESS, OP_KEY,    8'h41, 8'h00,       32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_KEY,    8'h42, 8'h00,       32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_STATUS, 32'h0, 1'b0, 9'd0);
        // limit of zero below the held count: drop keys, still pop
        add_row(ROW_LIMIT,  OP_KEY,    8'h00, 8'h00,       32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_KEY,    8'h43, 8'h00,       32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_DATA,   32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_STATUS, 32'h0, 1'b0, 9'd0);
        // largest limit the register holds
        add_row(ROW_LIMIT,  OP_KEY,    8'h00, 8'h00,       32'h0, 1'b0, 9'd511);
        add_row(ROW_ACCESS, OP_KEY,    8'h7E, 8'h00,       32'h0, 1'b0, 9'd0);
        add_row(ROW_ACCESS, OP_READ,   8'h00, ADDR_DATA,   32'h0, 1'b0, 9'd0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_LIMIT) begin
                write_limit(row.typed_val);
            end else begin
                send_access(row.op, row.key_code, row.address, row.write_data,
                            row.typed, row.typed_val);
            end
        end

        // Random phases, each under its own limit.
        for (int p = 0; p < PHASES; p++) begin
            write_limit(phase_limit[p] < 0 ? LIMIT_W'($urandom_range(1, 64))
                                           : LIMIT_W'(phase_limit[p]));
            for (int n = 0; n < phase_items[p]; n++) begin
                send_random(phase_keys[p], phase_wr[p]);
            end
        end

        // Drop valid, drain every owed result, then watch for strays.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (owed_reads.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d keys stored, %0d dropped, %0d pops, %0d clears",
                 keys_stored, keys_dropped, bytes_popped, fifo_clears);
        $display("checked %0d read results across %0d limit settings",
                 reads_checked, limit_writes);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/kfm_pkg.sv
src/kfm_datapath.sv
src/kfm_ctrl.sv
src/keyboard_fifo_mmio_core.sv
tb/sv/testbench.sv
